// File: rtl/ordered_priority_queue_defines.svh
// assertion macros used by the queue rtl
`ifndef ORDERED_PRIORITY_QUEUE_DEFINES_SVH
`define ORDERED_PRIORITY_QUEUE_DEFINES_SVH

// property that must hold at every edge outside reset
`define OPQ_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/opq_pkg.sv
package opq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TICKET_BITS_DEF = 16;
  localparam int IDENT_BITS_DEF  = 10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_code_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_cmd_t;

endpackage

// File: rtl/opq_in_if.sv
interface opq_in_if #(
  parameter int TICKET_BITS = opq_pkg::TICKET_BITS_DEF,
  parameter int IDENT_BITS  = opq_pkg::IDENT_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [TICKET_BITS-1:0] entry_ticket;
  logic [IDENT_BITS-1:0]  entry_ident;

  modport source (output valid, operation, entry_ticket, entry_ident, input ready);
  modport sink (input valid, operation, entry_ticket, entry_ident, output ready);
endinterface

// File: rtl/opq_out_if.sv
interface opq_out_if #(
  parameter int TICKET_BITS = opq_pkg::TICKET_BITS_DEF,
  parameter int IDENT_BITS  = opq_pkg::IDENT_BITS_DEF,
  parameter int COUNT_BITS  = $clog2(opq_pkg::QUEUE_DEPTH_DEF + 1)
);
  logic                   valid;
  logic                   ready;
  logic [TICKET_BITS-1:0] head_ticket;
  logic [IDENT_BITS-1:0]  head_ident;
  logic [COUNT_BITS-1:0]  occupancy;
  logic                   queue_empty;
  logic [1:0]             error_flag;

  modport source (output valid, head_ticket, head_ident, occupancy, queue_empty,
                  error_flag, input ready);
  modport sink (input valid, head_ticket, head_ident, occupancy, queue_empty,
                error_flag, output ready);
endinterface

// File: rtl/opq_cell.sv
module opq_cell #(
  parameter int TICKET_BITS = opq_pkg::TICKET_BITS_DEF,
  parameter int IDENT_BITS  = opq_pkg::IDENT_BITS_DEF
) (
  input  logic                   clk,
  input  opq_pkg::cell_cmd_t     cmd,
  input  logic                   occupied,
  input  logic [TICKET_BITS-1:0] new_ticket,
  input  logic [IDENT_BITS-1:0]  new_ident,
  input  logic                   prev_before,
  input  logic [TICKET_BITS-1:0] prev_ticket,
  input  logic [IDENT_BITS-1:0]  prev_ident,
  input  logic [TICKET_BITS-1:0] succ_ticket,
  input  logic [IDENT_BITS-1:0]  succ_ident,
  output logic                   ahead,
  output logic [TICKET_BITS-1:0] ticket,
  output logic [IDENT_BITS-1:0]  ident,
  output logic [TICKET_BITS-1:0] ticket_next,
  output logic [IDENT_BITS-1:0]  ident_next
);
  import opq_pkg::*;

  always_comb begin
    // an empty slot always counts as ahead, so it takes the new entry or the one shifted down
    ahead = !occupied || (new_ticket < ticket) ||
            ((new_ticket == ticket) && (new_ident > ident));
    ticket_next = ticket;
    ident_next  = ident;
    if (cmd.insert && ahead) begin
      if (prev_before) begin
        // slot ahead was bumped, so its old entry moves down into this one
        ticket_next = prev_ticket;
        ident_next  = prev_ident;
      end else begin
        ticket_next = new_ticket;
        ident_next  = new_ident;
      end
    end else if (cmd.remove) begin
      ticket_next = succ_ticket;
      ident_next  = succ_ident;
    end
  end

  always_ff @(posedge clk) begin
    ticket <= ticket_next;
    ident  <= ident_next;
  end

endmodule

// File: rtl/ordered_priority_queue.sv
// latency: a result beat is presented in the cycle after its item beat is accepted
// throughput: one insert or remove per cycle while results are taken
// each slot cell compares the broadcast entry against its own combinationally
// reset clears the entry count and the result valid flag; slot contents are not cleared
module ordered_priority_queue #(
  parameter int QUEUE_DEPTH = opq_pkg::QUEUE_DEPTH_DEF,
  parameter int TICKET_BITS = opq_pkg::TICKET_BITS_DEF,
  parameter int IDENT_BITS  = opq_pkg::IDENT_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  opq_in_if.sink   item,
  opq_out_if.source result
);
  import opq_pkg::*;
  `include "ordered_priority_queue_defines.svh"

  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [COUNT_BITS-1:0]  count;
  logic [COUNT_BITS-1:0]  count_next;
  logic                   full;
  logic                   accept;
  cell_cmd_t              cmd;
  err_code_t              err_code;

  logic                   cell_before [QUEUE_DEPTH];
  logic                   cell_occ    [QUEUE_DEPTH];
  logic [TICKET_BITS-1:0] cell_ticket [QUEUE_DEPTH];
  logic [IDENT_BITS-1:0]  cell_ident  [QUEUE_DEPTH];
  logic [TICKET_BITS-1:0] cell_ticket_next [QUEUE_DEPTH];
  logic [IDENT_BITS-1:0]  cell_ident_next  [QUEUE_DEPTH];

  assign full       = (count == COUNT_BITS'(QUEUE_DEPTH));
  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;

  always_comb begin
    cmd.insert = accept && (item.operation == OP_INSERT) && !full;
    cmd.remove = accept && (item.operation == OP_REMOVE) && (count != '0);
    count_next = count;
    if (cmd.insert) begin
      count_next = count + 1'b1;
    end else if (cmd.remove) begin
      count_next = count - 1'b1;
    end
    err_code = ERR_OK;
    if (item.operation == OP_INSERT) begin
      if (full) begin
        err_code = ERR_FULL;
      end
    end else if (count == '0) begin
      err_code = ERR_EMPTY;
    end
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic                   prev_before;
    logic [TICKET_BITS-1:0] prev_ticket;
    logic [IDENT_BITS-1:0]  prev_ident;
    logic [TICKET_BITS-1:0] succ_ticket;
    logic [IDENT_BITS-1:0]  succ_ident;

    assign cell_occ[k] = (count > COUNT_BITS'(k));

    if (k == 0) begin : g_head
      assign prev_before = 1'b0;
      assign prev_ticket = item.entry_ticket;
      assign prev_ident  = item.entry_ident;
    end else begin : g_body
      assign prev_before = cell_before[k-1];
      assign prev_ticket = cell_ticket[k-1];
      assign prev_ident  = cell_ident[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign succ_ticket = cell_ticket[k];
      assign succ_ident  = cell_ident[k];
    end else begin : g_link
      assign succ_ticket = cell_ticket[k+1];
      assign succ_ident  = cell_ident[k+1];
    end

    opq_cell #(
      .TICKET_BITS (TICKET_BITS),
      .IDENT_BITS  (IDENT_BITS)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (cell_occ[k]),
      .new_ticket  (item.entry_ticket),
      .new_ident   (item.entry_ident),
      .prev_before (prev_before),
      .prev_ticket (prev_ticket),
      .prev_ident  (prev_ident),
      .succ_ticket (succ_ticket),
      .succ_ident  (succ_ident),
      .ahead       (cell_before[k]),
      .ticket      (cell_ticket[k]),
      .ident       (cell_ident[k]),
      .ticket_next (cell_ticket_next[k]),
      .ident_next  (cell_ident_next[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // result beat reflects the queue after this item
  always_ff @(posedge clk) begin
    if (accept) begin
      result.occupancy   <= count_next;
      result.queue_empty <= (count_next == '0);
      result.error_flag  <= err_code;
      if (count_next == '0) begin
        result.head_ticket <= '0;
        result.head_ident  <= '0;
      end else begin
        result.head_ticket <= cell_ticket_next[0];
        result.head_ident  <= cell_ident_next[0];
      end
    end
  end

  `OPQ_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= COUNT_BITS'(QUEUE_DEPTH),
    "entry count above queue depth")
  `OPQ_ASSERT_NEXT(a_insert_grows, clk, rst, cmd.insert,
    count == COUNT_BITS'($past(count) + 1'b1), "insert did not grow the count")
  `OPQ_ASSERT_ALWAYS(a_empty_flag, clk, rst,
    !result.valid || (result.queue_empty == (result.occupancy == '0)),
    "empty flag disagrees with occupancy")
  `OPQ_ASSERT_ALWAYS(a_full_err, clk, rst,
    !result.valid || (result.error_flag != ERR_FULL) ||
    (result.occupancy == COUNT_BITS'(QUEUE_DEPTH)),
    "full error reported below depth")
  `OPQ_ASSERT_ALWAYS(a_head_order, clk, rst,
    (count < COUNT_BITS'(2)) || (cell_ticket[0] < cell_ticket[1]) ||
    ((cell_ticket[0] == cell_ticket[1]) && (cell_ident[0] >= cell_ident[1])),
    "head entry out of order")

endmodule

// File: tb/ordered_priority_queue_test.sv
module ordered_priority_queue_test;
  import opq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int TB = TICKET_BITS_DEF;
  localparam int IB = IDENT_BITS_DEF;
  localparam int CB = $clog2(DEPTH + 1);
  localparam int DIRECTED_ROWS = 23;
  localparam int RANDOM_ITEMS = 1827;

  typedef struct packed {
    logic [TB-1:0] head_ticket;
    logic [IB-1:0] head_ident;
    logic [CB-1:0] occupancy;
    logic queue_empty;
    err_code_t error_flag;
  } head_report_t;

  typedef struct packed {
    logic operation;
    logic [TB-1:0] entry_ticket;
    logic [IB-1:0] entry_ident;
    logic typed;
    head_report_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  opq_in_if item_bus ();
  opq_out_if result_bus ();

  ordered_priority_queue dut (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus)
  );

  // sorted shadow of the queue, slot 0 is the head
  logic [TB-1:0] shadow_ticket [DEPTH];
  logic [IB-1:0] shadow_ident [DEPTH];
  int shadow_count = 0;

  head_report_t pending_heads [$];
  int fail_count = 0;
  int idle_phase = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 55;

  // expectation typed into the table travels alongside the item beat
  logic beat_typed;
  head_report_t beat_want;

  // typed rows: after reset, extremes, tie order and both error codes
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_REMOVE, 16'h0000, 10'h000, 1'b1, '{16'h0000, 10'h000, 5'd0, 1'b1, ERR_EMPTY}},
    '{OP_INSERT, 16'hFFFF, 10'h3FF, 1'b1, '{16'hFFFF, 10'h3FF, 5'd1, 1'b0, ERR_OK}},
    '{OP_INSERT, 16'h0000, 10'h000, 1'b1, '{16'h0000, 10'h000, 5'd2, 1'b0, ERR_OK}},
    '{OP_INSERT, 16'h0000, 10'h3FF, 1'b1, '{16'h0000, 10'h3FF, 5'd3, 1'b0, ERR_OK}},
    '{OP_INSERT, 16'h0000, 10'h3FF, 1'b1, '{16'h0000, 10'h3FF, 5'd4, 1'b0, ERR_OK}},
    '{OP_INSERT, 16'hFFFF, 10'h000, 1'b0, '0},
    '{OP_INSERT, 16'h8000, 10'h155, 1'b0, '0},
    '{OP_INSERT, 16'h7FFF, 10'h2AA, 1'b0, '0},
    '{OP_INSERT, 16'h0001, 10'h200, 1'b0, '0},
    '{OP_INSERT, 16'hFFFE, 10'h001, 1'b0, '0},
    '{OP_INSERT, 16'h1234, 10'h0AA, 1'b0, '0},
    '{OP_INSERT, 16'h1234, 10'h0AA, 1'b0, '0},
    '{OP_INSERT, 16'h1234, 10'h3FE, 1'b0, '0},
    '{OP_INSERT, 16'h5555, 10'h355, 1'b0, '0},
    '{OP_INSERT, 16'hAAAA, 10'h0CC, 1'b0, '0},
    '{OP_INSERT, 16'h0000, 10'h001, 1'b0, '0},
    '{OP_INSERT, 16'h00FF, 10'h3FF, 1'b0, '0},
    '{OP_INSERT, 16'h0000, 10'h000, 1'b1, '{16'h0000, 10'h3FF, 5'd16, 1'b0, ERR_FULL}},
    '{OP_REMOVE, 16'hFFFF, 10'h3FF, 1'b0, '0},
    '{OP_REMOVE, 16'h0000, 10'h000, 1'b0, '0},
    '{OP_REMOVE, 16'hA5A5, 10'h15A, 1'b0, '0},
    '{OP_INSERT, 16'h0000, 10'h000, 1'b0, '0},
    '{OP_REMOVE, 16'h5A5A, 10'h2A5, 1'b0, '0}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic head_report_t apply_to_shadow(logic op, logic [TB-1:0] tk,
                                                   logic [IB-1:0] id);
    head_report_t r;
    int pos;
    r.error_flag = ERR_OK;
    if (op == OP_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.error_flag = ERR_FULL;
      end else begin
        pos = shadow_count;
        // first slot the new entry outranks; equal entries keep arrival order
        for (int k = 0; k < shadow_count; k++) begin
          if (pos == shadow_count &&
              (tk < shadow_ticket[k] || (tk == shadow_ticket[k] && id > shadow_ident[k])))
            pos = k;
        end
        for (int k = shadow_count; k > pos; k--) begin
          shadow_ticket[k] = shadow_ticket[k-1];
          shadow_ident[k] = shadow_ident[k-1];
        end
        shadow_ticket[pos] = tk;
        shadow_ident[pos] = id;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.error_flag = ERR_EMPTY;
      end else begin
        for (int k = 0; k + 1 < shadow_count; k++) begin
          shadow_ticket[k] = shadow_ticket[k+1];
          shadow_ident[k] = shadow_ident[k+1];
        end
        shadow_count--;
      end
    end
    r.head_ticket = (shadow_count > 0) ? shadow_ticket[0] : '0;
    r.head_ident = (shadow_count > 0) ? shadow_ident[0] : '0;
    r.occupancy = CB'(shadow_count);
    r.queue_empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // results are checked before the item beat of the same edge is predicted
  always @(posedge clk) begin : scoreboard
    head_report_t want;
    head_report_t guess;
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        if (pending_heads.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_heads[0];
          pending_heads.delete(0);
          compare_field("head_ticket", 32'(want.head_ticket), 32'(result_bus.head_ticket));
          compare_field("head_ident", 32'(want.head_ident), 32'(result_bus.head_ident));
          compare_field("occupancy", 32'(want.occupancy), 32'(result_bus.occupancy));
          compare_field("queue_empty", 32'(want.queue_empty), 32'(result_bus.queue_empty));
          compare_field("error_flag", 32'(want.error_flag), 32'(result_bus.error_flag));
        end
      end
      if (item_bus.valid && item_bus.ready) begin
        guess = apply_to_shadow(item_bus.operation, item_bus.entry_ticket,
                                item_bus.entry_ident);
        pending_heads.insert(pending_heads.size(), beat_typed ? beat_want : guess);
      end
    end
  end

  initial result_bus.ready = 1'b0;
  always @(posedge clk) result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_beat(input logic op, input logic [TB-1:0] tk,
                           input logic [IB-1:0] id, input logic typed,
                           input head_report_t want);
    item_bus.valid <= 1'b1;
    item_bus.operation <= op;
    item_bus.entry_ticket <= tk;
    item_bus.entry_ident <= id;
    beat_typed <= typed;
    beat_want <= want;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int mode;
    logic op;
    logic [TB-1:0] tk;
    logic [IB-1:0] id;
    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.operation = OP_INSERT;
    item_bus.entry_ticket = '0;
    item_bus.entry_ident = '0;
    beat_typed = 1'b0;
    beat_want = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].operation, directed_rows[i].entry_ticket,
                directed_rows[i].entry_ident, directed_rows[i].typed, directed_rows[i].want);

    mode = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
        // hold off until the queue has answered everything, then swap idling (off the second time)
        item_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_heads.size() != 0);
        idle_phase++;
        send_idle_pct = (idle_phase == 1) ? 55 : 0;
        recv_idle_pct = (idle_phase == 1) ? 33 : 0;
      end
      // fill, drain and mixed stretches so full and empty are both reached often
      if (n % 32 == 0) mode = $urandom_range(2);
      case (mode)
        0: op = ($urandom_range(99) < 80) ? OP_INSERT : OP_REMOVE;
        1: op = ($urandom_range(99) < 80) ? OP_REMOVE : OP_INSERT;
        default: op = 1'($urandom_range(1));
      endcase
      case ($urandom_range(3))
        0: tk = TB'($urandom_range(7));
        1: tk = $urandom_range(1) ? '1 : '0;
        default: tk = TB'($urandom);
      endcase
      case ($urandom_range(2))
        0: id = IB'($urandom_range(3));
        1: id = '1 - IB'($urandom_range(3));
        default: id = IB'($urandom);
      endcase
      send_beat(op, tk, id, 1'b0, '0);
    end

    item_bus.valid <= 1'b0;
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("ordered_priority_queue_test OK");
    end else begin
      $display("ordered_priority_queue_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("ordered_priority_queue_test NOT OK");
    $finish;
  end

endmodule
